>>> hdl/swrm_pkg.sv
// Shared types and constants of the sliding-window rate meter.
`default_nettype none

package swrm_pkg;

   // Item codes on req_command
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // Register index, taken from the configuration address
   localparam int  CSR_ADDR_W = 4;
   localparam logic REG_WINDOW = 1'b0;

   localparam int WINDOW_W = 40;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd1000000000;
   localparam logic [29:0] NS_PER_S = 30'd1000000000;
   localparam logic [63:0] MIN_ELAPSED_NS = 64'd1000000;

   // Controller -> datapath
   typedef struct packed {
      logic rec_write;     // store a packet record
      logic query_load;    // latch query time, cutoff, clear accumulators
      logic walk_issue;    // read the next ring slot
      logic scale_lo;      // low partial product, latch divisor
      logic scale_hi;      // add high partial product, clear divider
      logic div_step;      // one restoring division step
      logic res_load_zero; // result register <= 0
      logic res_load_div;  // result register <= saturated quotient
   } swrm_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic empty;
      logic walk_last;
      logic total_zero;
      logic div_last;
   } swrm_stat_type;

endpackage

`default_nettype wire

>>> hdl/swrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module swrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/swrm_ctrl.sv
// Sequencing state machine of the sliding-window rate meter.
`default_nettype none

module swrm_ctrl
   import swrm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_command,
   input  swrm_stat_type      stat,
   output swrm_cmd_type       cmd,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == CMD_RECORD) begin
                  cmd.rec_write = 1'b1;
               end else begin
                  cmd.query_load = 1'b1;
                  if (stat.empty) begin
                     cmd.res_load_zero = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end else begin
                     state_in = ST_WALK;
                     busy_in  = 1'b1;
                  end
               end
            end
         end
         ST_WALK: begin
            cmd.walk_issue = 1'b1;
            if (stat.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCALE_LO;
         end
         ST_SCALE_LO: begin
            if (stat.total_zero) begin
               cmd.res_load_zero = 1'b1;
               rsp_valid_in      = 1'b1;
               busy_in           = 1'b0;
               state_in          = ST_IDLE;
            end else begin
               cmd.scale_lo = 1'b1;
               state_in     = ST_SCALE_HI;
            end
         end
         ST_SCALE_HI: begin
            cmd.scale_hi = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.res_load_div = 1'b1;
            rsp_valid_in     = 1'b1;
            busy_in          = 1'b0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hdl/swrm_dpath.sv
// Datapath: record ring, window walk, scaling multiply and serial divider.
`default_nettype none

module swrm_dpath
   import swrm_pkg::*;
#(
   parameter int SAMPLE_SLOTS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  swrm_cmd_type             cmd,
   input  wire logic [31:0]         req_packet_bytes,
   input  wire logic [63:0]         req_time_ns,
   input  wire logic [WINDOW_W-1:0] window_len,
   output swrm_stat_type            stat,
   output logic      [63:0]         rsp_bytes_per_second
);

   localparam int PtrW  = $clog2(SAMPLE_SLOTS);
   localparam int CntW  = $clog2(SAMPLE_SLOTS + 1);
   localparam int SumW  = 32 + CntW;
   localparam int HiW   = SumW - 32;
   localparam int ProdW = SumW + 30;
   localparam int StepW = $clog2(ProdW);

   // ring bookkeeping
   logic [PtrW-1:0] wp_ff, wp_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [PtrW-1:0] addr_ff, addr_in;
   logic            rd_pend_ff;

   // query state
   logic [63:0]      now_ff, now_in;
   logic [63:0]      cutoff_ff, cutoff_in;
   logic [63:0]      oldest_ff, oldest_in;
   logic [SumW-1:0]  total_ff, total_in;
   logic [63:0]      den_ff, den_in;
   logic [63:0]      rem_ff, rem_in;
   logic [ProdW-1:0] div_ff, div_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [63:0]      res_ff, res_in;

   logic [63:0]          stamp_rd;
   logic [31:0]          size_rd;
   logic [63:0]          win;
   logic [63:0]          elapsed;
   logic [61:0]          prod_lo;
   logic [HiW+29:0]      prod_hi;
   logic [64:0]          shift_rem;
   logic [64:0]          trial;
   logic                 q_bit;

   swrm_ram #(.WIDTH(64), .DEPTH(SAMPLE_SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (cmd.rec_write),
      .wr_addr (wp_ff),
      .wr_data (req_time_ns),
      .rd_addr (addr_ff),
      .rd_data (stamp_rd)
   );

   swrm_ram #(.WIDTH(32), .DEPTH(SAMPLE_SLOTS)) u_size_ram (
      .clock   (clock),
      .wr_en   (cmd.rec_write),
      .wr_addr (wp_ff),
      .wr_data (req_packet_bytes),
      .rd_addr (addr_ff),
      .rd_data (size_rd)
   );

   always_comb begin
      win       = (window_len == '0) ? 64'(WINDOW_RESET) : 64'(window_len);
      elapsed   = now_ff - oldest_ff;
      prod_lo   = total_ff[31:0] * NS_PER_S;
      prod_hi   = total_ff[SumW-1:32] * NS_PER_S;
      shift_rem = {rem_ff, div_ff[ProdW-1]};
      trial     = shift_rem - {1'b0, den_ff};
      q_bit     = ~trial[64];

      wp_in     = wp_ff;
      fill_in   = fill_ff;
      addr_in   = addr_ff;
      now_in    = now_ff;
      cutoff_in = cutoff_ff;
      oldest_in = oldest_ff;
      total_in  = total_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      step_in   = step_ff;
      res_in    = res_ff;

      if (cmd.rec_write) begin
         wp_in = (wp_ff == PtrW'(SAMPLE_SLOTS - 1)) ? '0 : wp_ff + PtrW'(1);
         if (fill_ff != CntW'(SAMPLE_SLOTS)) begin
            fill_in = fill_ff + CntW'(1);
         end
      end

      if (cmd.query_load) begin
         // slots 0 .. fill-1 hold the last fill records written
         now_in    = req_time_ns;
         cutoff_in = (req_time_ns > win) ? req_time_ns - win : '0;
         oldest_in = req_time_ns;
         total_in  = '0;
         addr_in   = '0;
      end else if (rd_pend_ff && (stamp_rd >= cutoff_ff)) begin
         total_in = total_ff + SumW'(size_rd);
         if (stamp_rd < oldest_ff) begin
            oldest_in = stamp_rd;
         end
      end

      if (cmd.walk_issue) begin
         addr_in = addr_ff + PtrW'(1);
      end

      if (cmd.scale_lo) begin
         div_in = ProdW'(prod_lo);
         den_in = (elapsed < MIN_ELAPSED_NS) ? MIN_ELAPSED_NS : elapsed;
      end

      if (cmd.scale_hi) begin
         div_in  = div_ff + {prod_hi, 32'b0};
         rem_in  = '0;
         step_in = '0;
      end

      if (cmd.div_step) begin
         rem_in  = q_bit ? trial[63:0] : shift_rem[63:0];
         div_in  = {div_ff[ProdW-2:0], q_bit};
         step_in = step_ff + StepW'(1);
      end

      if (cmd.res_load_zero) begin
         res_in = '0;
      end else if (cmd.res_load_div) begin
         res_in = (div_ff > ProdW'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : div_ff[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         fill_ff    <= '0;
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         addr_ff    <= addr_in;
         rd_pend_ff <= cmd.walk_issue;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff    <= now_in;
      cutoff_ff <= cutoff_in;
      oldest_ff <= oldest_in;
      total_ff  <= total_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      res_ff    <= res_in;
   end

   assign stat.empty      = (fill_ff == '0);
   assign stat.walk_last  = ((CntW'(addr_ff) + CntW'(1)) == fill_ff);
   assign stat.total_zero = (total_ff == '0);
   assign stat.div_last   = (step_ff == StepW'(ProdW - 1));

   assign rsp_bytes_per_second = res_ff;

endmodule

`default_nettype wire

>>> hdl/sliding_window_rate_meter.sv
// Top level of the sliding-window rate meter: register port, controller, datapath.
//
//   channel | ports                                   | transfer
//   --------+-----------------------------------------+---------------------------------
//   request | start, busy, req_command,               | edge with start high, busy low
//           | req_packet_bytes, req_time_ns           |
//   result  | rsp_valid, rsp_bytes_per_second         | one-cycle strobe, cannot stall
//   config  | psel, penable, pwrite, paddr, pwdata,   | access phase, pready tied high
//           | prdata, pready                          |
//
// A record is stored on its accepting edge; busy stays low, the next item may follow at once.
// A query on an empty ring strobes 0 in the next cycle, busy stays low.
// Otherwise busy is high through the walk (one RAM read per held record) and a drain; a zero
// qualifying sum ends it there, else a scale and P = 62 + clog2(SAMPLE_SLOTS+1) divider steps.
// The strobe comes in the first cycle with busy low; the receiver cannot stall it.
// Synchronous reset empties the ring (pointer and fill count) and sets the window to 1e9 ns.
`default_nettype none

module sliding_window_rate_meter
   import swrm_pkg::*;
#(
   parameter int SAMPLE_SLOTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_command,
   input  wire logic [31:0]           req_packet_bytes,
   input  wire logic [63:0]           req_time_ns,
   // result channel
   output logic                       rsp_valid,
   output logic      [63:0]           rsp_bytes_per_second,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [63:0]           pwdata,
   output logic      [63:0]           prdata,
   output logic                       pready
);

   swrm_cmd_type  cmd;
   swrm_stat_type stat;

   logic [WINDOW_W-1:0] window_ff, window_in;
   logic                csr_write;
   logic                csr_hit;

   // 8-byte register slots; the top address bit picks the register
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1] == REG_WINDOW);
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      window_in = window_ff;
      if (csr_write && csr_hit) begin
         window_in = pwdata[WINDOW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata = csr_hit ? 64'(window_ff) : '0;

   swrm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   swrm_dpath #(.SAMPLE_SLOTS(SAMPLE_SLOTS)) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_packet_bytes     (req_packet_bytes),
      .req_time_ns          (req_time_ns),
      .window_len           (window_ff),
      .stat                 (stat),
      .rsp_bytes_per_second (rsp_bytes_per_second)
   );

endmodule

`default_nettype wire

>>> tb/swrm_checker.sv
// Checker for the sliding-window rate meter: predicts each query's rate and compares results.
`timescale 1ns / 1ps

module swrm_checker
   import swrm_pkg::*;
#(
   parameter int SAMPLE_SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_command,
   input  logic [31:0]           req_packet_bytes,
   input  logic [63:0]           req_time_ns,
   input  logic                  rsp_valid,
   input  logic [63:0]           rsp_bytes_per_second,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [63:0]           pwdata,
   input  logic                  pready,
   output int unsigned           pending,
   output int unsigned           fail_count
);

   logic [63:0]         stamp_ring [SAMPLE_SLOTS];
   logic [31:0]         size_ring  [SAMPLE_SLOTS];
   int unsigned         wr_slot;
   int unsigned         held;
   logic [WINDOW_W-1:0] window;
   logic [63:0]         rate_queue [$];
   logic [63:0]         want;
   int unsigned         errors = 0;

   assign pending    = rate_queue.size();
   assign fail_count = errors;

   // bytes per second over the held records that fall inside the window
   function automatic logic [63:0] predict_rate(input logic [63:0] now);
      logic [63:0]  win;
      logic [63:0]  cutoff;
      logic [63:0]  total;
      logic [63:0]  oldest;
      logic [63:0]  elapsed;
      logic [127:0] scaled;
      int unsigned  first;
      int unsigned  slot;
      int unsigned  i;
      if (held == 0)
         return '0;
      win    = (window == '0) ? 64'(WINDOW_RESET) : 64'(window);
      cutoff = (now > win) ? now - win : '0;
      total  = '0;
      oldest = now;
      first  = wr_slot + SAMPLE_SLOTS - held;
      for (i = 0; i < held; i++) begin
         slot = (first + i) % SAMPLE_SLOTS;
         if (stamp_ring[slot] >= cutoff) begin
            total += 64'(size_ring[slot]);
            if (stamp_ring[slot] < oldest)
               oldest = stamp_ring[slot];
         end
      end
      if (total == '0)
         return '0;
      elapsed = now - oldest;
      if (elapsed < MIN_ELAPSED_NS)
         elapsed = MIN_ELAPSED_NS;
      scaled = 128'(total) * 128'(NS_PER_S);
      if (scaled[127:64] >= elapsed)
         return '1;
      return 64'(scaled / 128'(elapsed));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wr_slot = 0;
         held    = 0;
         window  = WINDOW_RESET;
         rate_queue.delete();
      end else begin
         // result first: a new item may be taken in the same cycle
         if (rsp_valid !== 1'b0) begin
            if (rate_queue.size() == 0) begin
               $error("unexpected result: bytes_per_second = %0d", rsp_bytes_per_second);
               errors++;
            end else begin
               want = rate_queue.pop_front();
               if (rsp_bytes_per_second !== want) begin
                  $error("bytes_per_second: expected %0d, actual %0d",
                         want, rsp_bytes_per_second);
                  errors++;
               end
            end
         end
         if (psel && penable && pwrite && pready && (paddr >> 3) == CSR_ADDR_W'(REG_WINDOW))
            window = pwdata[WINDOW_W-1:0];
         if (start && !busy) begin
            if (req_command == CMD_RECORD) begin
               stamp_ring[wr_slot] = req_time_ns;
               size_ring[wr_slot]  = req_packet_bytes;
               wr_slot = (wr_slot + 1) % SAMPLE_SLOTS;
               if (held < SAMPLE_SLOTS)
                  held++;
            end else begin
               rate_queue.push_back(predict_rate(req_time_ns));
            end
         end
      end
   end

endmodule

>>> tb/sliding_window_rate_meter_tb.sv
// Testbench top of the sliding-window rate meter: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module sliding_window_rate_meter_tb
   import swrm_pkg::*;
();

   localparam int SLOTS = 64;
   // cycle cap for the whole run
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   // records leave busy low, so a short settle covers them
   localparam int unsigned SETTLE = 8;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = CSR_ADDR_W'(REG_WINDOW) << 3;
   // index 1: no register lives there, writes must be dropped
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(8);

   logic                  clock;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic                  req_command      = CMD_RECORD;
   logic [31:0]           req_packet_bytes = '0;
   logic [63:0]           req_time_ns      = '0;
   logic                  rsp_valid;
   logic [63:0]           rsp_bytes_per_second;
   logic                  psel             = 1'b0;
   logic                  penable          = 1'b0;
   logic                  pwrite           = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr            = '0;
   logic [63:0]           pwdata           = '0;
   logic [63:0]           prdata;
   logic                  pready;

   int unsigned pending;
   int unsigned fail_count;
   int unsigned cycles  = 0;
   logic [63:0] now     = '0;
   logic        no_gaps = 1'b0;

   sliding_window_rate_meter #(.SAMPLE_SLOTS(SLOTS)) uut (
      .clock, .reset,
      .start, .busy, .req_command, .req_packet_bytes, .req_time_ns,
      .rsp_valid, .rsp_bytes_per_second,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   swrm_checker #(.SAMPLE_SLOTS(SLOTS)) u_checker (
      .clock, .reset,
      .start, .busy, .req_command, .req_packet_bytes, .req_time_ns,
      .rsp_valid, .rsp_bytes_per_second,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .pending, .fail_count
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idle cycles after a transfer: mostly none, some short, a few long enough
   // to land anywhere inside a query's walk or divide.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(12, 150);
   endfunction

   // Packet sizes: typical frames, full 32-bit range, zero, all-ones and small sizes.
   function automatic logic [31:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(0, 1500);
      if (r < 75)
         return $urandom;
      if (r < 87)
         return '0;
      if (r < 94)
         return '1;
      return $urandom_range(1, 64);
   endfunction

   // One item; start stays up until the transfer, then an optional gap.
   // Called just after a rising edge, returns just after one.
   task automatic send_item(input logic cmd, input logic [31:0] nbytes,
                            input logic [63:0] t_ns);
      int unsigned gap;
      req_command      <= cmd;
      req_packet_bytes <= nbytes;
      req_time_ns      <= t_ns;
      start            <= 1'b1;
      // busy is settled mid-cycle; low here means the next edge takes the item
      do @(negedge clock); while (busy);
      @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every expected rate has come back.
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; pready is tied high.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // One window setting. Time moves forward in steps scaled to the window so
   // the 64-slot ring straddles the cutoff; a few records land in the future
   // or the past, and some items are pure noise.
   task automatic run_phase(input logic [63:0] wdata, input logic [63:0] base,
                            input int unsigned count, input logic quiet);
      logic [63:0] win;
      logic [63:0] step_max;
      int unsigned i;
      int unsigned r;
      drain();
      write_csr(WINDOW_ADDR, wdata);
      win      = (wdata[WINDOW_W-1:0] == '0) ? 64'(WINDOW_RESET) : 64'(wdata[WINDOW_W-1:0]);
      step_max = win / 24 + 1;
      no_gaps  = quiet;
      now      = base;
      for (i = 0; i < count; i++) begin
         now += rand64() % (step_max + 1);
         r = $urandom_range(0, 99);
         if (r < 55)
            send_item(CMD_RECORD, pick_size(), now);
         else if (r < 58)
            send_item(CMD_RECORD, pick_size(), now + rand64() % (2 * win));
         else if (r < 61)
            send_item(CMD_RECORD, pick_size(), now - rand64() % (2 * win));
         else if (r < 95)
            send_item(CMD_QUERY, $urandom, now);
         else
            send_item(1'($urandom), $urandom, rand64());
      end
      no_gaps = 1'b0;
   endtask

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, default window of one second ----
      send_item(CMD_QUERY, 32'd0, 64'd0);                    // empty ring
      send_item(CMD_QUERY, '1, '1);                          // empty ring, top time
      send_item(CMD_RECORD, 32'd0, 64'd0);
      send_item(CMD_QUERY, 32'd0, 64'd5);                    // zero sum, cutoff floors at 0
      send_item(CMD_RECORD, '1, 64'd1000);
      send_item(CMD_QUERY, 32'd0, 64'd2000);                 // short elapsed, clamped
      send_item(CMD_RECORD, 32'd1500, 64'd3_000_000_000);    // future vs next query
      send_item(CMD_QUERY, 32'd0, 64'd2_000_000_000);
      send_item(CMD_RECORD, 32'd12345, '1);                  // stamp that always qualifies
      send_item(CMD_QUERY, '1, '1);
      drain();
      // write to the unused index must leave the window at one second
      write_csr(SPARE_ADDR, 64'd1);
      send_item(CMD_QUERY, 32'd0, 64'd3_000_000_500);
      drain();
      // minimum window; upper data bits are outside the register
      write_csr(WINDOW_ADDR, {24'hFFFFFF, 40'd1});
      send_item(CMD_RECORD, 32'd777, 64'd5_000_000_000);
      send_item(CMD_QUERY, 32'd0, 64'd5_000_000_001);        // stamp exactly at cutoff
      send_item(CMD_QUERY, 32'd0, 64'd5_000_000_002);        // just outside
      send_item(CMD_RECORD, 32'd9, 64'd5_000_000_002);
      send_item(CMD_QUERY, 32'd0, 64'd5_000_000_002);
      drain();
      // zero window falls back to one second
      write_csr(WINDOW_ADDR, 64'd0);
      send_item(CMD_QUERY, 32'd0, 64'd6_000_000_002);

      // ---- random part: one phase per window setting ----
      run_phase(64'd1_000_000_000, 64'd0, 68, 1'b0);
      run_phase(64'd0, 64'h8000_0000_0000_0000, 68, 1'b0);
      run_phase({24'd0, 40'd1}, 64'd7_000, 68, 1'b1);
      run_phase({24'($urandom), 40'hFF_FFFF_FFFF}, 64'hFFFF_F000_0000_0000, 68, 1'b0);
      run_phase(64'd5_000_000, rand64(), 68, 1'b0);
      run_phase(64'd100_000, 64'd123_456_789, 68, 1'b1);
      run_phase({24'd0, 16'($urandom), 24'($urandom)}, rand64() >> 2, 68, 1'b0);
      run_phase({24'($urandom), 40'd30_000_000}, 64'd50_000_000_000, 68, 1'b0);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/swrm_pkg.sv
hdl/swrm_ram.sv
hdl/swrm_ctrl.sv
hdl/swrm_dpath.sv
hdl/sliding_window_rate_meter.sv
tb/swrm_checker.sv
tb/sliding_window_rate_meter_tb.sv
